// ===== rtl/jddm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_pkg
// Shared types, widths and fixed-point constants of the joystick mixer.
// ----------------------------------------------------------------------------
package jddm_pkg;

	localparam int unsigned POS_W     = 12;
	localparam int unsigned SET_W     = 7;
	localparam int unsigned MODE_W    = 4;
	localparam int unsigned DUTY_W    = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 12;
	localparam int unsigned SCALE_W   = 7;
	localparam int unsigned OPND_W    = 13;
	localparam int unsigned COEF_W    = 17;
	localparam int unsigned PROD_W    = OPND_W + COEF_W;
	localparam int unsigned MIX_W     = 32;
	localparam int unsigned SPROD_W   = PROD_W + SCALE_W;
	localparam int unsigned DIFF_W    = 14;

	// Q1.16 mixing coefficients; K_UNIT carries an integer duty through the mixer
	localparam logic [COEF_W-1:0] K_HI   = 17'd47101;
	localparam logic [COEF_W-1:0] K_MID  = 17'd37375;
	localparam logic [COEF_W-1:0] K_LO   = 17'd9719;
	localparam logic [COEF_W-1:0] K_UNIT = 17'd65536;

	localparam logic [OPND_W-1:0]  SPIN_DUTY = 13'd736;
	localparam logic [POS_W-1:0]   MID       = 12'd2048;
	localparam logic [DIFF_W-1:0]  MID_D     = 14'd2048;
	localparam logic [SCALE_W-1:0] MAX_SCALE = 7'd89;
	localparam logic [SET_W-1:0]   SET_TOP   = 7'd99;
	localparam logic [DUTY_W-1:0]  DUTY_MAX  = 16'hFFFF;
	localparam logic [DUTY_W-1:0]  DUTY_STOP = 16'd1;

	localparam logic [CFG_W-1:0] RST_CENTER_LOW  = 12'd1700;
	localparam logic [CFG_W-1:0] RST_CENTER_HIGH = 12'd2200;
	localparam logic [CFG_W-1:0] RST_FWD_LOW     = 12'd1800;
	localparam logic [CFG_W-1:0] RST_FWD_HIGH    = 12'd2200;
	localparam logic [CFG_W-1:0] RST_REV_LOW     = 12'd1800;
	localparam logic [CFG_W-1:0] RST_REV_HIGH    = 12'd2200;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_LOW  = 3'd0,
		CFG_CENTER_HIGH = 3'd1,
		CFG_FWD_LOW     = 3'd2,
		CFG_FWD_HIGH    = 3'd3,
		CFG_REV_LOW     = 3'd4,
		CFG_REV_HIGH    = 3'd5
	} cfg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_SPIN_REV = 4'd1,
		MODE_STOP     = 4'd2,
		MODE_SPIN_FWD = 4'd3
	} spin_mode_t;

	typedef enum logic [1:0] {
		OUT_RUN  = 2'd0,
		OUT_STOP = 2'd1,
		OUT_HOLD = 2'd2
	} out_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_CLASS   = 3'd1,
		ST_LEFT_A  = 3'd2,
		ST_LEFT_B  = 3'd3,
		ST_RIGHT_A = 3'd4,
		ST_RIGHT_B = 3'd5,
		ST_RIGHT_S = 3'd6,
		ST_FINISH  = 3'd7
	} state_t;

	typedef struct packed {
		logic load;
		logic classify;
		logic term_en;
		logic term_right;
		logic term_second;
		logic scale_left;
		logic scale_right;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic skip_math;
	} dp_status_t;

endpackage

// ===== rtl/jddm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_ctrl
// Sequencer: steps the shared multipliers and owns both handshakes.
// ----------------------------------------------------------------------------
module jddm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	output logic                result_valid,
	input  logic                result_ready,
	input  jddm_pkg::dp_status_t status,
	output jddm_pkg::dp_cmd_t    cmd
);
	import jddm_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		sample_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CLASS;
				end
			end
			ST_CLASS: begin
				cmd.classify = 1'b1;
				state_d      = status.skip_math ? ST_FINISH : ST_LEFT_A;
			end
			ST_LEFT_A: begin
				cmd.term_en = 1'b1;
				state_d     = ST_LEFT_B;
			end
			ST_LEFT_B: begin
				cmd.term_en     = 1'b1;
				cmd.term_second = 1'b1;
				state_d         = ST_RIGHT_A;
			end
			ST_RIGHT_A: begin
				cmd.term_en    = 1'b1;
				cmd.term_right = 1'b1;
				cmd.scale_left = 1'b1;
				state_d        = ST_RIGHT_B;
			end
			ST_RIGHT_B: begin
				cmd.term_en     = 1'b1;
				cmd.term_right  = 1'b1;
				cmd.term_second = 1'b1;
				state_d         = ST_RIGHT_S;
			end
			ST_RIGHT_S: begin
				cmd.scale_right = 1'b1;
				state_d         = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/jddm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_datapath
// Threshold registers, region decode, shared mixing multipliers, output hold.
// ----------------------------------------------------------------------------
module jddm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  jddm_pkg::dp_cmd_t             cmd,
	output jddm_pkg::dp_status_t          status,
	input  logic [jddm_pkg::POS_W-1:0]    x_position,
	input  logic [jddm_pkg::POS_W-1:0]    y_position,
	input  logic [jddm_pkg::SET_W-1:0]    speed_setting,
	input  logic [jddm_pkg::MODE_W-1:0]   spin_mode,
	input  logic                          cfg_we,
	input  logic [jddm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [jddm_pkg::CFG_W-1:0]    cfg_data,
	output logic                          left_forward,
	output logic                          right_forward,
	output logic [jddm_pkg::DUTY_W-1:0]   left_duty,
	output logic [jddm_pkg::DUTY_W-1:0]   right_duty,
	output logic                          held
);
	import jddm_pkg::*;

	// threshold registers
	logic [CFG_W-1:0] center_low_q, center_high_q;
	logic [CFG_W-1:0] fwd_low_q, fwd_high_q, rev_low_q, rev_high_q;

	// latched request
	logic [POS_W-1:0]  x_q, y_q;
	logic [SET_W-1:0]  set_q;
	logic [MODE_W-1:0] mode_q;

	// decode results
	out_kind_t         kind_d, kind_q;
	logic              lf_d, rf_d, lf_q, rf_q;
	logic [SCALE_W-1:0] scale_d, scale_q;
	logic [OPND_W-1:0] lp1_d, lp2_d, rp1_d, rp2_d;
	logic [COEF_W-1:0] lc1_d, lc2_d, rc1_d, rc2_d;
	logic [OPND_W-1:0] lp1_q, lp2_q, rp1_q, rp2_q;
	logic [COEF_W-1:0] lc1_q, lc2_q, rc1_q, rc2_q;

	// math
	logic [OPND_W-1:0]  mul_p;
	logic [COEF_W-1:0]  mul_c;
	logic [PROD_W-1:0]  term_prod;
	logic signed [MIX_W-1:0] acc_l_q, acc_r_q, acc_sel, acc_next;
	logic [SPROD_W-1:0] scale_prod;
	logic [DUTY_W-1:0]  duty_d, duty_l_q, duty_r_q;

	// previous non-held outputs
	logic [DUTY_W-1:0] last_ld_q, last_rd_q;
	logic              last_lf_q, last_rf_q;

	logic signed [DIFF_W-1:0] dx, fy, lx, ry;
	logic in_center;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_low_q  <= RST_CENTER_LOW;
			center_high_q <= RST_CENTER_HIGH;
			fwd_low_q     <= RST_FWD_LOW;
			fwd_high_q    <= RST_FWD_HIGH;
			rev_low_q     <= RST_REV_LOW;
			rev_high_q    <= RST_REV_HIGH;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CENTER_LOW:  center_low_q  <= cfg_data;
				CFG_CENTER_HIGH: center_high_q <= cfg_data;
				CFG_FWD_LOW:     fwd_low_q     <= cfg_data;
				CFG_FWD_HIGH:    fwd_high_q    <= cfg_data;
				CFG_REV_LOW:     rev_low_q     <= cfg_data;
				CFG_REV_HIGH:    rev_high_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= x_position;
			y_q    <= y_position;
			set_q  <= speed_setting;
			mode_q <= spin_mode;
		end
	end

	// offsets from center, signed
	assign dx = $signed({2'b00, x_q}) - $signed(MID_D);
	assign fy = $signed({2'b00, y_q}) - $signed(MID_D);
	assign lx = $signed(MID_D) - $signed({2'b00, x_q});
	assign ry = $signed(MID_D) - $signed({2'b00, y_q});

	assign in_center = (x_q > center_low_q) && (x_q < center_high_q)
		&& (y_q > center_low_q) && (y_q < center_high_q);

	always_comb begin
		logic signed [DIFF_W-1:0] rdiff;
		rdiff   = '0;
		kind_d  = OUT_RUN;
		lf_d    = 1'b0;
		rf_d    = 1'b0;
		lp1_d   = '0;
		lp2_d   = '0;
		rp1_d   = '0;
		rp2_d   = '0;
		lc1_d   = K_HI;
		lc2_d   = K_MID;
		rc1_d   = K_HI;
		rc2_d   = K_MID;
		if (set_q > SET_TOP) begin
			scale_d = '0;
		end else if ((SET_TOP - set_q) > MAX_SCALE) begin
			scale_d = MAX_SCALE;
		end else begin
			scale_d = SET_TOP - set_q;
		end

		if (in_center) begin
			case (mode_q)
				MODE_STOP: kind_d = OUT_STOP;
				MODE_SPIN_REV, MODE_SPIN_FWD: begin
					lp1_d = SPIN_DUTY;
					rp1_d = SPIN_DUTY;
					lc1_d = K_UNIT;
					rc1_d = K_UNIT;
					lf_d  = (mode_q == MODE_SPIN_FWD);
					rf_d  = (mode_q == MODE_SPIN_REV);
				end
				default: kind_d = OUT_HOLD;
			endcase
		end else if (y_q > MID) begin
			lf_d = 1'b1;
			rf_d = 1'b1;
			if ((x_q > fwd_low_q) && (x_q < fwd_high_q)) begin
				lp1_d = fy[OPND_W-1:0];
				rp1_d = fy[OPND_W-1:0];
			end else if (x_q > MID) begin
				if (y_q > x_q) begin
					lp1_d = fy[OPND_W-1:0];
					rp1_d = fy[OPND_W-1:0];
					rp2_d = dx[OPND_W-1:0];
				end else begin
					lp1_d = dx[OPND_W-1:0];
					rp1_d = fy[OPND_W-1:0];
					rc1_d = K_LO;
				end
			end else if (fy > lx) begin
				lp1_d = fy[OPND_W-1:0];
				lp2_d = lx[OPND_W-1:0];
				rp1_d = fy[OPND_W-1:0];
			end else begin
				lp1_d = fy[OPND_W-1:0];
				lc1_d = K_LO;
				rp1_d = lx[OPND_W-1:0];
			end
		end else begin
			if ((x_q > rev_low_q) && (x_q < rev_high_q)) begin
				lp1_d = ry[OPND_W-1:0];
				rp1_d = ry[OPND_W-1:0];
			end else if (x_q >= rev_high_q) begin
				rdiff = ry - dx;
				if (dx < ry) begin
					lp1_d = ry[OPND_W-1:0];
					rp1_d = rdiff[OPND_W-1:0];
				end else begin
					kind_d = OUT_STOP;
				end
			end else if (x_q <= rev_low_q) begin
				rdiff = ry - lx;
				if (lx < ry) begin
					rp1_d = ry[OPND_W-1:0];
					lp1_d = rdiff[OPND_W-1:0];
				end else begin
					kind_d = OUT_STOP;
				end
			end else begin
				kind_d = OUT_STOP;
			end
		end
	end

	assign status.skip_math = (kind_d != OUT_RUN);

	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			kind_q  <= kind_d;
			lf_q    <= lf_d;
			rf_q    <= rf_d;
			scale_q <= scale_d;
			lp1_q   <= lp1_d;
			lp2_q   <= lp2_d;
			rp1_q   <= rp1_d;
			rp2_q   <= rp2_d;
			lc1_q   <= lc1_d;
			lc2_q   <= lc2_d;
			rc1_q   <= rc1_d;
			rc2_q   <= rc2_d;
		end
	end

	// shared offset-times-coefficient multiplier
	always_comb begin
		case ({cmd.term_right, cmd.term_second})
			2'b00: begin mul_p = lp1_q; mul_c = lc1_q; end
			2'b01: begin mul_p = lp2_q; mul_c = lc2_q; end
			2'b10: begin mul_p = rp1_q; mul_c = rc1_q; end
			default: begin mul_p = rp2_q; mul_c = rc2_q; end
		endcase
	end

	assign term_prod = PROD_W'(mul_p) * PROD_W'(mul_c);

	always_comb begin
		if (cmd.term_second) begin
			acc_next = (cmd.term_right ? acc_r_q : acc_l_q)
				- $signed(MIX_W'(term_prod));
		end else begin
			acc_next = $signed(MIX_W'(term_prod));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.term_en && !cmd.term_right) begin
			acc_l_q <= acc_next;
		end
		if (cmd.term_en && cmd.term_right) begin
			acc_r_q <= acc_next;
		end
	end

	// shared mix-times-scale multiplier, then truncate and saturate
	assign acc_sel    = cmd.scale_left ? acc_l_q : acc_r_q;
	assign scale_prod = SPROD_W'(acc_sel[PROD_W-1:0]) * SPROD_W'(scale_q);

	always_comb begin
		if (acc_sel[MIX_W-1] || (acc_sel == '0)) begin
			duty_d = '0;
		end else if (scale_prod[SPROD_W-1:DUTY_W+16] != '0) begin
			duty_d = DUTY_MAX;
		end else begin
			duty_d = scale_prod[DUTY_W+15:16];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scale_left) begin
			duty_l_q <= duty_d;
		end
		if (cmd.scale_right) begin
			duty_r_q <= duty_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ld_q <= '0;
			last_rd_q <= '0;
			last_lf_q <= 1'b0;
			last_rf_q <= 1'b0;
		end else if (cmd.finish) begin
			case (kind_q)
				OUT_RUN: begin
					last_ld_q <= duty_l_q;
					last_rd_q <= duty_r_q;
					last_lf_q <= lf_q;
					last_rf_q <= rf_q;
				end
				OUT_STOP: begin
					last_ld_q <= DUTY_STOP;
					last_rd_q <= DUTY_STOP;
					last_lf_q <= 1'b0;
					last_rf_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			case (kind_q)
				OUT_RUN: begin
					left_duty     <= duty_l_q;
					right_duty    <= duty_r_q;
					left_forward  <= lf_q;
					right_forward <= rf_q;
					held          <= 1'b0;
				end
				OUT_STOP: begin
					left_duty     <= DUTY_STOP;
					right_duty    <= DUTY_STOP;
					left_forward  <= 1'b0;
					right_forward <= 1'b0;
					held          <= 1'b0;
				end
				default: begin
					left_duty     <= last_ld_q;
					right_duty    <= last_rd_q;
					left_forward  <= last_lf_q;
					right_forward <= last_rf_q;
					held          <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== rtl/joystick_differential_drive_mixer_core.sv =====
`timescale 1ns / 1ps
// Sequence: a sample that needs the multipliers is accepted, decoded, then runs
//   two offset products per side and two scale products before its result is valid;
//   stop and hold outcomes skip the multipliers and go from decode to the result.
// A new request is taken only once the previous one has left the sequence;
//   a waiting result does not block acceptance of the next request.
// Reset: thresholds return to 1700/2200/1800/2200/1800/2200, stored outputs to 0.
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer_core
// Mixes a joystick sample into left/right motor direction and PWM duty.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  logic [jddm_pkg::POS_W-1:0]     x_position,
	input  logic [jddm_pkg::POS_W-1:0]     y_position,
	input  logic [jddm_pkg::SET_W-1:0]     speed_setting,
	input  logic [jddm_pkg::MODE_W-1:0]    spin_mode,
	// result channel
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic                           left_forward,
	output logic                           right_forward,
	output logic [jddm_pkg::DUTY_W-1:0]    left_duty,
	output logic [jddm_pkg::DUTY_W-1:0]    right_duty,
	output logic                           held,
	// threshold write port
	input  logic                           cfg_we,
	input  logic [jddm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [jddm_pkg::CFG_W-1:0]     cfg_data
);
	import jddm_pkg::*;

	// Controller issues one command per cycle; the datapath reports only
	// whether the decoded region needs the multipliers at all.
	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer: accept in idle, decode, left terms, right terms with the left
	// scale product overlapped, right scale product, then publish the result
	// once the output register is free or being drained; stop and hold skip the math.
	jddm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// Datapath: threshold registers, region decode into operand/coefficient
	// pairs, shared multipliers, saturation, and the held-output memory.
	// The spin duty rides the same path with a unit coefficient so that
	// 736 times the scale falls out of the common truncating shift.
	jddm_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.x_position    (x_position),
		.y_position    (y_position),
		.speed_setting (speed_setting),
		.spin_mode     (spin_mode),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.left_forward  (left_forward),
		.right_forward (right_forward),
		.left_duty     (left_duty),
		.right_duty    (right_duty),
		.held          (held)
	);

endmodule

// ===== bench/joystick_differential_drive_mixer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer_core_tb
// Drives joystick samples into the mixer and checks every direction/duty
// result against a cycle-free prediction of the mixing rules. Covers each
// drive region, the center actions, speed extremes, several threshold sets
// and back-pressure on both channels.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer_core_tb;

	import jddm_pkg::*;

	// spin codes outside 1..3 keep the previous outputs
	localparam logic [MODE_W-1:0] MODE_HOLD     = 4'd0;
	localparam logic [MODE_W-1:0] MODE_HOLD_TOP = 4'd15;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int IDLE_PCT       = 22;
	localparam int TAIL_CYCLES    = 16;

	typedef struct packed {
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [SET_W-1:0]  setting;
		logic [MODE_W-1:0] mode;
	} sample_t;

	typedef struct packed {
		logic              lf;
		logic              rf;
		logic [DUTY_W-1:0] ld;
		logic [DUTY_W-1:0] rd;
		logic              held;
	} drive_t;

	// ------------------------------------------------------------------------
	// DUT ports; every input starts at a known value
	// ------------------------------------------------------------------------
	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 sample_valid  = 1'b0;
	logic                 sample_ready;
	logic [POS_W-1:0]     x_position    = '0;
	logic [POS_W-1:0]     y_position    = '0;
	logic [SET_W-1:0]     speed_setting = '0;
	logic [MODE_W-1:0]    spin_mode     = '0;
	logic                 result_valid;
	logic                 result_ready  = 1'b0;
	logic                 left_forward;
	logic                 right_forward;
	logic [DUTY_W-1:0]    left_duty;
	logic [DUTY_W-1:0]    right_duty;
	logic                 held;
	logic                 cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [CFG_W-1:0]     cfg_data      = '0;

	joystick_differential_drive_mixer_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.x_position    (x_position),
		.y_position    (y_position),
		.speed_setting (speed_setting),
		.spin_mode     (spin_mode),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.left_forward  (left_forward),
		.right_forward (right_forward),
		.left_duty     (left_duty),
		.right_duty    (right_duty),
		.held          (held),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Mixer prediction: threshold copy, last non-held drive, expected results
	// ------------------------------------------------------------------------
	logic [CFG_W-1:0] thr [6];
	drive_t           last_drive;
	drive_t           pending_drives [$];

	// steady: neither side idles; rx_hold_req: receiver starts a long stall
	bit steady      = 1'b0;
	bit rx_hold_req = 1'b0;

	int n_samples    = 0;
	int n_results    = 0;
	int n_mismatch   = 0;
	int n_held       = 0;
	int n_saturated  = 0;
	int n_settings   = 1;

	task automatic reset_prediction();
		thr[CFG_CENTER_LOW]  = RST_CENTER_LOW;
		thr[CFG_CENTER_HIGH] = RST_CENTER_HIGH;
		thr[CFG_FWD_LOW]     = RST_FWD_LOW;
		thr[CFG_FWD_HIGH]    = RST_FWD_HIGH;
		thr[CFG_REV_LOW]     = RST_REV_LOW;
		thr[CFG_REV_HIGH]    = RST_REV_HIGH;
		last_drive           = '0;
	endtask

	// Q15.16 mix times scale, truncated; non-positive mixes give zero duty
	function automatic logic [DUTY_W-1:0] duty_of(longint mix, longint scale);
		longint p;
		if (mix <= 0)
			return '0;
		p = (mix * scale) >>> 16;
		if (p > 65535)
			p = 65535;
		return p[DUTY_W-1:0];
	endfunction

	function automatic drive_t mix_sample(sample_t s);
		longint kh, km, kl, mid, sx, sy, scale, fy, lx, ry, lm, rm;
		drive_t d;
		logic   stop;
		kh    = longint'(K_HI);
		km    = longint'(K_MID);
		kl    = longint'(K_LO);
		mid   = longint'(MID);
		sx    = longint'(s.x);
		sy    = longint'(s.y);
		scale = (s.setting > SET_TOP) ? longint'(0)
		                              : longint'(SET_TOP) - longint'(s.setting);
		if (scale > longint'(MAX_SCALE))
			scale = longint'(MAX_SCALE);
		d    = '{1'b0, 1'b0, DUTY_STOP, DUTY_STOP, 1'b0};
		stop = 1'b0;

		if (s.x > thr[CFG_CENTER_LOW] && s.x < thr[CFG_CENTER_HIGH] &&
		    s.y > thr[CFG_CENTER_LOW] && s.y < thr[CFG_CENTER_HIGH]) begin
			case (s.mode)
				MODE_STOP: stop = 1'b1;
				MODE_SPIN_REV, MODE_SPIN_FWD: begin
					d.ld = DUTY_W'(longint'(SPIN_DUTY) * scale);
					d.rd = d.ld;
					d.lf = (s.mode == MODE_SPIN_FWD);
					d.rf = (s.mode == MODE_SPIN_REV);
				end
				default: begin
					// hold: repeat the last drive, state untouched
					d      = last_drive;
					d.held = 1'b1;
					return d;
				end
			endcase
		end else if (s.y > MID) begin
			fy = sy - mid;
			if (s.x > thr[CFG_FWD_LOW] && s.x < thr[CFG_FWD_HIGH]) begin
				lm = fy * kh;
				rm = lm;
			end else if (sx > mid) begin
				if (sy > sx) begin
					lm = fy * kh;
					rm = fy * kh - (sx - mid) * km;
				end else begin
					lm = (sx - mid) * kh;
					rm = fy * kl;
				end
			end else begin
				lx = mid - sx;
				if (fy > lx) begin
					lm = fy * kh - lx * km;
					rm = fy * kh;
				end else begin
					lm = fy * kl;
					rm = lx * kh;
				end
			end
			d.lf = 1'b1;
			d.rf = 1'b1;
			d.ld = duty_of(lm, scale);
			d.rd = duty_of(rm, scale);
		end else begin
			ry = mid - sy;
			if (s.x > thr[CFG_REV_LOW] && s.x < thr[CFG_REV_HIGH]) begin
				d.ld = duty_of(ry * kh, scale);
				d.rd = d.ld;
			end else if (s.x >= thr[CFG_REV_HIGH]) begin
				if ((sx - mid) < ry) begin
					d.ld = duty_of(ry * kh, scale);
					d.rd = duty_of((ry - (sx - mid)) * kh, scale);
				end else
					stop = 1'b1;
			end else if (s.x <= thr[CFG_REV_LOW]) begin
				if ((mid - sx) < ry) begin
					d.rd = duty_of(ry * kh, scale);
					d.ld = duty_of((ry - (mid - sx)) * kh, scale);
				end else
					stop = 1'b1;
			end else
				stop = 1'b1;
		end

		if (stop)
			d = '{1'b0, 1'b0, DUTY_STOP, DUTY_STOP, 1'b0};
		last_drive = d;
		return d;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [POS_W-1:0] near(int v, int d);
		int r;
		r = v + int'($urandom_range(2 * d)) - d;
		if (r < 0)
			r = 0;
		if (r > 4095)
			r = 4095;
		return r[POS_W-1:0];
	endfunction

	// Mostly well-formed joystick points, biased toward region borders
	function automatic sample_t random_sample();
		sample_t s;
		int      lo, hi, t, ry;
		s.x = POS_W'($urandom_range(4095));
		s.y = POS_W'($urandom_range(4095));
		case ($urandom_range(9))
			0, 1: begin
				// inside (or just around) the center dead zone
				lo = int'(thr[CFG_CENTER_LOW]);
				hi = int'(thr[CFG_CENTER_HIGH]);
				if (lo > hi) begin
					t  = lo;
					lo = hi;
					hi = t;
				end
				s.x = POS_W'($urandom_range(hi, lo));
				s.y = POS_W'($urandom_range(hi, lo));
				if ($urandom_range(2) == 0)
					s.x = near(($urandom_range(1) != 0) ? lo : hi, 2);
			end
			2: s.x = near(int'(thr[$urandom_range(5)]), 2);
			3: s.y = near(int'(MID), 3);
			4: s.x = near(int'(MID), 3);
			5: begin
				// reverse turn at the edge of too sharp
				s.y = POS_W'($urandom_range(2047));
				ry  = 2048 - int'(s.y);
				s.x = near(($urandom_range(1) != 0) ? 2048 + ry : 2048 - ry, 2);
			end
			6: begin
				// forward quadrant split lines
				s.y = POS_W'($urandom_range(4095, 2049));
				s.x = ($urandom_range(1) != 0) ? near(int'(s.y), 2)
				                               : near(4096 - int'(s.y), 2);
			end
			default: ;
		endcase
		s.setting = ($urandom_range(9) == 0) ? SET_W'($urandom_range(127, 100))
		                                     : SET_W'($urandom_range(99));
		s.mode    = ($urandom_range(4) == 0) ? MODE_W'($urandom_range(15))
		                                     : MODE_W'($urandom_range(3));
		return s;
	endfunction

	function automatic logic [CFG_W-1:0] random_threshold();
		if ($urandom_range(9) < 2)
			return CFG_W'($urandom_range(4095));
		return CFG_W'($urandom_range(2600, 1500));
	endfunction

	// ------------------------------------------------------------------------
	// Request side: idle at random, hold valid until accepted, then predict
	// ------------------------------------------------------------------------
	task automatic send_sample(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
	                           input logic [SET_W-1:0] setting,
	                           input logic [MODE_W-1:0] mode);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				sample_valid <= 1'b0;
				@(posedge clk);
			end
		end
		sample_valid  <= 1'b1;
		x_position    <= x;
		y_position    <= y;
		speed_setting <= setting;
		spin_mode     <= mode;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		pending_drives.push_back(mix_sample('{x, y, setting, mode}));
		n_samples++;
	endtask

	task automatic send_random(input int count);
		sample_t s;
		repeat (count) begin
			s = random_sample();
			send_sample(s.x, s.y, s.setting, s.mode);
		end
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (pending_drives.size() != 0)
			@(posedge clk);
	endtask

	// Write all six thresholds back to back while the block is idle
	task automatic apply_thresholds(input logic [CFG_W-1:0] cl, input logic [CFG_W-1:0] ch,
	                                input logic [CFG_W-1:0] fl, input logic [CFG_W-1:0] fh,
	                                input logic [CFG_W-1:0] rl, input logic [CFG_W-1:0] rh);
		logic [CFG_W-1:0] vals [6];
		vals = '{cl, ch, fl, fh, rl, rh};
		wait_drained();
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data  <= vals[i];
			thr[i]     = vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Dead zone: stop, both spins, hold after a spin and after a stop
	task automatic test_center_actions();
		send_sample(12'd2048, 12'd2048, 7'd0,   MODE_SPIN_REV);
		send_sample(12'd2048, 12'd2048, 7'd0,   MODE_HOLD);
		send_sample(12'd1701, 12'd2199, 7'd40,  MODE_SPIN_FWD);
		send_sample(12'd2199, 12'd1701, 7'd99,  MODE_HOLD_TOP);
		send_sample(12'd2000, 12'd2100, 7'd127, MODE_SPIN_FWD);
		send_sample(12'd2000, 12'd2000, 7'd5,   MODE_STOP);
		send_sample(12'd2000, 12'd2000, 7'd5,   4'd9);
	endtask

	// Every drive region, corner saturation and speed extremes
	task automatic test_drive_regions();
		send_sample(12'd2000, 12'd4095, 7'd0,   MODE_HOLD);     // forward straight, saturates
		send_sample(12'd3000, 12'd3500, 7'd10,  MODE_HOLD);     // quadrant one, y above x
		send_sample(12'd3500, 12'd3000, 7'd10,  MODE_SPIN_REV); // quadrant one, x above y
		send_sample(12'd1500, 12'd3000, 7'd50,  MODE_STOP);     // quadrant two, mostly forward
		send_sample(12'd500,  12'd2300, 7'd50,  MODE_HOLD);     // quadrant two, mostly lateral
		send_sample(12'd2000, 12'd0,    7'd99,  MODE_HOLD);     // reverse straight, zero scale
		send_sample(12'd2000, 12'd500,  7'd0,   MODE_HOLD);     // reverse straight
		send_sample(12'd2500, 12'd1000, 7'd20,  MODE_HOLD);     // reverse right turn
		send_sample(12'd3200, 12'd1000, 7'd20,  MODE_HOLD);     // reverse right, too sharp
		send_sample(12'd1500, 12'd1000, 7'd20,  MODE_HOLD);     // reverse left turn
		send_sample(12'd800,  12'd1000, 7'd20,  MODE_HOLD);     // reverse left, too sharp
		send_sample(12'd0,    12'd4095, 7'd0,   MODE_HOLD_TOP);
		send_sample(12'd4095, 12'd4095, 7'd0,   MODE_HOLD);
		send_sample(12'd0,    12'd0,    7'd100, MODE_HOLD);
		send_sample(12'd4095, 12'd0,    7'd1,   MODE_HOLD);
	endtask

	// Random traffic at reset thresholds, first without idling on either side
	task automatic test_random_traffic();
		steady = 1'b1;
		send_random(200);
		steady = 1'b0;
		send_random(300);
	endtask

	// Receiver stalls for a long stretch; the sender keeps offering until
	// the block fills and stops taking requests
	task automatic test_output_backpressure();
		wait_drained();
		steady      = 1'b1;
		rx_hold_req = 1'b1;
		send_random(24);
		steady = 1'b0;
		wait_drained();
	endtask

	// Bursts separated by full drains
	task automatic test_sender_pause();
		repeat (3) begin
			send_random(20);
			wait_drained();
		end
	endtask

	// Extreme, inverted, wide and random threshold sets
	task automatic test_threshold_sweep();
		apply_thresholds(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
		send_random(100);
		apply_thresholds(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		send_random(100);
		apply_thresholds(12'd2200, 12'd1700, 12'd2200, 12'd1800, 12'd2200, 12'd1800);
		send_random(100);
		apply_thresholds(12'd0, 12'hFFF, 12'd0, 12'hFFF, 12'd0, 12'hFFF);
		send_random(100);
		repeat (4) begin
			apply_thresholds(random_threshold(), random_threshold(), random_threshold(),
			                 random_threshold(), random_threshold(), random_threshold());
			send_random(100);
		end
		apply_thresholds(RST_CENTER_LOW, RST_CENTER_HIGH, RST_FWD_LOW, RST_FWD_HIGH,
		                 RST_REV_LOW, RST_REV_HIGH);
		send_random(50);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		reset_prediction();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_center_actions();
		test_drive_regions();
		test_random_traffic();
		test_output_backpressure();
		test_sender_pause();
		test_threshold_sweep();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d joystick samples over %0d threshold sets, %0d results checked",
		         n_samples, n_settings, n_results);
		$display("%0d held outputs, %0d saturated duties, %0d mismatches",
		         n_held, n_saturated, n_mismatch);
		if (n_mismatch == 0)
			$display("joystick_differential_drive_mixer_core_tb passed");
		else
			$display("joystick_differential_drive_mixer_core_tb failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side: random stalls, one long hold on request
	// ------------------------------------------------------------------------
	int rx_hold_left = 0;

	always @(posedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req  = 1'b0;
			rx_hold_left = RX_HOLD_CYCLES;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			result_ready <= 1'b0;
		end else if (steady)
			result_ready <= 1'b1;
		else
			result_ready <= ($urandom_range(99) >= IDLE_PCT);
	end

	// Count a mismatch; print only the first ten
	task automatic check_field(input string name, input int unsigned want,
	                           input int unsigned got);
		if (want != got) begin
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("result %0d: %s expected %0d, got %0d", n_results, name, want, got);
		end
	endtask

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		drive_t want;
		if (arst_n && result_valid && result_ready) begin
			n_results++;
			if (held)
				n_held++;
			if (left_duty == DUTY_MAX || right_duty == DUTY_MAX)
				n_saturated++;
			if (pending_drives.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("result %0d arrived with no sample pending", n_results);
			end else begin
				want = pending_drives.pop_front();
				check_field("left_forward",  want.lf,   left_forward);
				check_field("right_forward", want.rf,   right_forward);
				check_field("left_duty",     want.ld,   left_duty);
				check_field("right_duty",    want.rd,   right_duty);
				check_field("held",          want.held, held);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run when neither channel moves for too long
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				quiet_cycles <= 0;
			else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("no handshake for %0d cycles, %0d results still pending",
				         quiet_cycles, pending_drives.size());
				$display("joystick_differential_drive_mixer_core_tb failed");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

// ===== joystick_differential_drive_mixer_core.f =====
rtl/jddm_pkg.sv
rtl/jddm_ctrl.sv
rtl/jddm_datapath.sv
rtl/joystick_differential_drive_mixer_core.sv
bench/joystick_differential_drive_mixer_core_tb.sv
